FILE: design/sorted_date_table_core_macros.svh
// assertion helpers for the sorted date table
`ifndef SORTED_DATE_TABLE_CORE_MACROS_SVH
`define SORTED_DATE_TABLE_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SDT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SDT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sdt_pkg.sv
package sdt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] name_key;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] birth_year;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  entry_count;
      logic [31:0] out_name_key;
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [11:0] out_year;
   } rsp_type;

   typedef struct packed {
      logic [31:0] name_key;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // broadcast from the controller to every cell
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } cell_ctrl_type;

endpackage

FILE: design/sdt_cell.sv
module sdt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sdt_pkg::cell_ctrl_type ctrl,
   input  sdt_pkg::entry_type    left_entry,
   input  logic                  left_valid,
   input  logic                  left_le,
   input  sdt_pkg::entry_type    right_entry,
   input  logic                  right_valid,
   input  logic                  prefix_in,
   output sdt_pkg::entry_type    entry,
   output logic                  valid,
   output logic                  le,
   output logic                  prefix_out
);
   import sdt_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      match;

   // held date sorts at or before the new one
   assign le         = valid_ff &&
                       ({entry_ff.month, entry_ff.day} <= {ctrl.item.month, ctrl.item.day});
   assign match      = valid_ff && (entry_ff.name_key == ctrl.item.name_key);
   // set from the first matching cell onward
   assign prefix_out = prefix_in | match;
   assign entry      = entry_ff;
   assign valid      = valid_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         if (!le) begin
            if (left_le) begin
               entry_in = ctrl.item;
               valid_in = 1'b1;
            end else begin
               entry_in = left_entry;
               valid_in = left_valid;
            end
         end
      end else if (ctrl.remove && prefix_out) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: design/sorted_date_table_core.sv
// Sorted date table: a row of TABLE_DEPTH cells, each holding one entry, kept
// ordered by month then day with equal dates in arrival order. Every request
// is first registered; then, once the response register is free, all cells
// compare against the broadcast request at once and shift by one place
// toward their neighbor (insert opens a gap, delete closes one at the first key
// match). A read picks the cell at the given position. Each request gives one
// response with a status and the entry count; the response sits in an output
// register, so the next request is taken while it waits. In the cells, reset
// only clears the valid flags, with no clearing pass.
module sorted_date_table_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdt_pkg::rsp_type rsp_payload
);
   import sdt_pkg::*;

   `include "sorted_date_table_core_macros.svh"

   req_type              req_ff;
   logic                 busy_ff, busy_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 exec;
   logic                 req_take;
   logic                 bad_item, full;
   logic [ENTRY_W-1:0]   rd_bits;
   entry_type            rd_entry;
   logic                 rd_hit;
   cell_ctrl_type        ctrl;

   entry_type            cell_entry [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_valid, cell_le, cell_prefix, rd_sel;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = busy_ff;
   assign exec      = busy_ff && !(rsp_valid_ff && rsp_stall);

   assign bad_item = (req_ff.name_key == '0) || (req_ff.day == '0) ||
                     (req_ff.month == '0) || (req_ff.birth_year == '0);
   assign full     = (count_ff == COUNT_W'(TABLE_DEPTH));

   always_comb begin
      ctrl.item.name_key = req_ff.name_key;
      ctrl.item.day      = req_ff.day;
      ctrl.item.month    = req_ff.month;
      ctrl.item.year     = req_ff.birth_year;
      ctrl.insert        = exec && (req_ff.command == CMD_INSERT) && !bad_item && !full;
      ctrl.remove        = exec && (req_ff.command == CMD_DELETE);
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type lentry, rentry;
      logic      lvalid, lle, rvalid, pin;

      if (i == 0) begin : g_first
         assign lentry = '0;
         assign lvalid = 1'b0;
         assign lle    = 1'b1;
         assign pin    = 1'b0;
      end else begin : g_mid
         assign lentry = cell_entry[i-1];
         assign lvalid = cell_valid[i-1];
         assign lle    = cell_le[i-1];
         assign pin    = cell_prefix[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign rentry = '0;
         assign rvalid = 1'b0;
      end else begin : g_inner
         assign rentry = cell_entry[i+1];
         assign rvalid = cell_valid[i+1];
      end

      assign rd_sel[i] = cell_valid[i] && (32'(req_ff.read_index) == 32'(i));

      sdt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (lentry),
         .left_valid  (lvalid),
         .left_le     (lle),
         .right_entry (rentry),
         .right_valid (rvalid),
         .prefix_in   (pin),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .le          (cell_le[i]),
         .prefix_out  (cell_prefix[i])
      );
   end

   always_comb begin
      rd_bits = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (rd_sel[i]) begin
            rd_bits = rd_bits | cell_entry[i];
         end
      end
   end

   assign rd_entry = entry_type'(rd_bits);
   assign rd_hit   = |rd_sel;

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      unique case (req_ff.command)
         CMD_INSERT: begin
            if (bad_item) begin
               rsp_in.status = ST_INVALID;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_OK;
               count_in      = count_ff + 1'b1;
            end
         end
         CMD_DELETE: begin
            if (cell_prefix[TABLE_DEPTH-1]) begin
               rsp_in.status = ST_OK;
               count_in      = count_ff - 1'b1;
            end else begin
               rsp_in.status = ST_MISSING;
            end
         end
         CMD_READ: begin
            if (rd_hit) begin
               rsp_in.status       = ST_OK;
               rsp_in.out_name_key = rd_entry.name_key;
               rsp_in.out_day      = rd_entry.day;
               rsp_in.out_month    = rd_entry.month;
               rsp_in.out_year     = rd_entry.year;
            end else begin
               rsp_in.status = ST_MISSING;
            end
         end
         default: begin
            rsp_in.status = ST_INVALID;
         end
      endcase
      rsp_in.entry_count = 7'(count_in);
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end else if (exec) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SDT_ASSERT(a_count_matches_cells, $countones(cell_valid) == int'(count_ff), "count differs from valid cells")
   `SDT_ASSERT(a_cells_packed, ((cell_valid + 1'b1) & cell_valid) == '0, "valid cells not packed at the front")
   `SDT_ASSERT_NEXT(a_exec_gives_rsp, exec, rsp_valid_ff && !busy_ff, "executed request gave no response")

endmodule
